[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used across the scan sequencer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition observed");

`endif

[hw/rtl/adcs_pkg.sv]
// ---------------------------------------------------------------------------
// ADC scan sequencer package
// Types, codes and constants shared by the scan sequencer modules.
// ---------------------------------------------------------------------------
package adcs_pkg;

	localparam int CHANNELS    = 4;
	localparam int CH_W        = 2;
	localparam int ADDR_W      = 7;
	localparam int WORD_W      = 16;
	localparam int SAMPLE_W    = 17;
	localparam int FAIL_W      = 8;
	localparam int CMD_W       = 2;
	localparam int ACT_W       = 3;
	localparam int PTR_W       = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;
	localparam int QUEUE_CNT_W = 3;

	localparam logic [CMD_W-1:0] CMD_BUS   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ALERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_KICK  = 2'd2;

	localparam logic [ACT_W-1:0] ACT_REG_WRITE  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_CONV_READ  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_PROBE_READ = 3'd2;
	localparam logic [ACT_W-1:0] ACT_RETRY      = 3'd3;
	localparam logic [ACT_W-1:0] ACT_SAMPLE     = 3'd4;

	localparam logic [PTR_W-1:0] PTR_CONV   = 2'd0;
	localparam logic [PTR_W-1:0] PTR_CONFIG = 2'd1;
	localparam logic [PTR_W-1:0] PTR_LO_THR = 2'd2;
	localparam logic [PTR_W-1:0] PTR_HI_THR = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LIMIT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CONFIG_RESET = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HI_THRESHOLD = 2'd2;

	localparam logic [FAIL_W-1:0] FAIL_LIMIT_DEFAULT   = 8'd10;
	localparam logic [FAIL_W-1:0] FAIL_MAX             = 8'hFF;
	localparam logic [WORD_W-1:0] CONFIG_RESET_DEFAULT = 16'h8583;
	localparam logic [WORD_W-1:0] HI_THRESHOLD_DEFAULT = 16'h8000;

	localparam logic [ADDR_W-1:0] PROBE_ADDR_BASE = 7'h48;
	localparam logic [ADDR_W-1:0] ADDR_NONE       = 7'h00;

	localparam logic [WORD_W-1:0] CFG_MUX_MASK    = 16'hF000;
	localparam logic [WORD_W-1:0] CFG_MUX_SE_BASE = 16'h4000;
	localparam logic [WORD_W-1:0] CFG_SINGLE_SHOT = 16'h8000;
	localparam int                CFG_MUX_LSB     = 12;

	typedef enum logic [2:0] {
		PH_PROBE,
		PH_LO_DONE,
		PH_HI_DONE,
		PH_WAIT,
		PH_POLL
	} phase_t;

	typedef enum logic [2:0] {
		JOB_RETRY,
		JOB_PROBE,
		JOB_CONV_READ,
		JOB_WRITE,
		JOB_SAMPLE
	} job_kind_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [ADDR_W-1:0] bus_addr;
		logic              timed_out;
		logic              aborted;
		logic              stop_seen;
		logic [WORD_W-1:0] read_data;
	} event_req_t;

	typedef struct packed {
		logic [ACT_W-1:0]    action;
		logic [ADDR_W-1:0]   target_addr;
		logic [PTR_W-1:0]    reg_pointer;
		logic [WORD_W-1:0]   write_word;
		logic [CH_W-1:0]     sample_channel;
		logic [SAMPLE_W-1:0] sample_value;
		logic                last;
	} result_req_t;

	typedef struct packed {
		job_kind_t           kind;
		logic [ADDR_W-1:0]   addr;
		logic [PTR_W-1:0]    pointer;
		logic [WORD_W-1:0]   word;
		logic [CH_W-1:0]     channel;
		logic [SAMPLE_W-1:0] value;
	} job_t;

endpackage

[hw/rtl/adc_channel_scan_sequencer.sv]
// ---------------------------------------------------------------------------
// ADC channel scan sequencer
// Drives a four-input I2C ADC: probing, threshold and config setup, sampling
// on alerts, channel rotation and failure fallback.
// ---------------------------------------------------------------------------
// An event request is accepted in any cycle in which the four-entry job queue
// has room, and its effect on the device phase is settled in that same cycle.
// Result requests leave one per cycle from a registered output stage while
// result_ready is high, and an event yields four results for a probe sweep,
// two for a sample, one for a register write, conversion read or retry, and
// none for an ignored event. Sustained throughput is therefore set by the
// result rate of the back end and by result_ready back-pressure.
module adc_channel_scan_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [adcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [adcs_pkg::WORD_W-1:0]    cfg_wdata,
	input  logic                           event_valid,
	output logic                           event_ready,
	input  adcs_pkg::event_req_t           event_req,
	output logic                           result_valid,
	input  logic                           result_ready,
	output adcs_pkg::result_req_t          result_req
);

	logic           push, full, pop, head_valid;
	adcs_pkg::job_t push_job, head_job;

	adcs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.event_valid (event_valid),
		.event_ready (event_ready),
		.event_req   (event_req),
		.queue_full  (full),
		.push        (push),
		.push_job    (push_job)
	);

	adcs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	adcs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_job     (head_job),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_req   (result_req)
	);

endmodule

[hw/rtl/adcs_front.sv]
// ---------------------------------------------------------------------------
// Scan sequencer front end
// Accepts bus and alert events, advances the device phase and queues one job
// per event that calls for bus traffic, a retry or a sample.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module adcs_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [adcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [adcs_pkg::WORD_W-1:0]    cfg_wdata,
	input  logic                           event_valid,
	output logic                           event_ready,
	input  adcs_pkg::event_req_t           event_req,
	input  logic                           queue_full,
	output logic                           push,
	output adcs_pkg::job_t                 push_job
);

	adcs_pkg::phase_t                 phase_q, phase_d, kick_phase;
	logic [adcs_pkg::FAIL_W-1:0]      fail_limit_q;
	logic [adcs_pkg::WORD_W-1:0]      cfg_reset_q;
	logic [adcs_pkg::WORD_W-1:0]      hi_thr_q;
	logic [adcs_pkg::FAIL_W-1:0]      fail_q, fail_d, fail_inc;
	logic [adcs_pkg::CH_W-1:0]        ch_q, ch_d;
	logic [adcs_pkg::WORD_W-1:0]      cw_q, cw_d;
	logic [adcs_pkg::ADDR_W-1:0]      dev_q, dev_d;
	logic [adcs_pkg::CHANNELS-1:0]    seen_q, seen_d;
	logic                             accept, foreign, do_kick, job_valid;
	adcs_pkg::job_t                   job;

	assign event_ready = !queue_full;
	assign accept      = event_valid && event_ready;
	assign push        = accept && job_valid;
	assign push_job    = job;

	assign foreign = (phase_q != adcs_pkg::PH_PROBE) &&
		(event_req.bus_addr != adcs_pkg::ADDR_NONE) && (event_req.bus_addr != dev_q);
	assign fail_inc = ((phase_q != adcs_pkg::PH_PROBE) && (fail_q != adcs_pkg::FAIL_MAX)) ?
		fail_q + 8'd1 : fail_q;
	assign kick_phase = (event_req.command == adcs_pkg::CMD_ALERT) ?
		adcs_pkg::PH_POLL : phase_q;

	always_comb begin
		phase_d   = phase_q;
		fail_d    = fail_q;
		ch_d      = ch_q;
		cw_d      = cw_q;
		dev_d     = dev_q;
		seen_d    = seen_q;
		do_kick   = 1'b0;
		job_valid = 1'b0;
		job       = '{kind: adcs_pkg::JOB_RETRY, default: '0};
		unique case (event_req.command)
			adcs_pkg::CMD_BUS: begin
				if (foreign) begin
					job_valid = 1'b0;
				end else if (event_req.timed_out || event_req.aborted) begin
					fail_d = fail_inc;
					if ((fail_inc > fail_limit_q) || (phase_q == adcs_pkg::PH_PROBE)) begin
						phase_d = adcs_pkg::PH_PROBE;
					end
					job_valid = 1'b1;
					job.kind  = adcs_pkg::JOB_RETRY;
				end else if (!event_req.stop_seen) begin
					do_kick = 1'b1;
				end else begin
					for (int i = 0; i < adcs_pkg::CHANNELS; i++) begin
						seen_d[i] = (event_req.bus_addr ==
							adcs_pkg::ADDR_W'(adcs_pkg::PROBE_ADDR_BASE + i));
					end
					fail_d = '0;
					job.addr = dev_q;
					unique case (phase_q)
						adcs_pkg::PH_PROBE: begin
							cw_d        = cfg_reset_q;
							phase_d     = adcs_pkg::PH_LO_DONE;
							dev_d       = event_req.bus_addr;
							job_valid   = 1'b1;
							job.kind    = adcs_pkg::JOB_WRITE;
							job.addr    = event_req.bus_addr;
							job.pointer = adcs_pkg::PTR_LO_THR;
						end
						adcs_pkg::PH_LO_DONE: begin
							phase_d     = adcs_pkg::PH_HI_DONE;
							job_valid   = 1'b1;
							job.kind    = adcs_pkg::JOB_WRITE;
							job.pointer = adcs_pkg::PTR_HI_THR;
							job.word    = hi_thr_q;
						end
						adcs_pkg::PH_HI_DONE: begin
							phase_d     = adcs_pkg::PH_WAIT;
							job_valid   = 1'b1;
							job.kind    = adcs_pkg::JOB_WRITE;
							job.pointer = adcs_pkg::PTR_CONFIG;
							job.word    = cw_q;
						end
						adcs_pkg::PH_POLL: begin
							ch_d        = ch_q + 2'd1;
							cw_d        = (cw_q & ~adcs_pkg::CFG_MUX_MASK) |
								(adcs_pkg::CFG_MUX_SE_BASE +
								 adcs_pkg::WORD_W'({ch_d, {adcs_pkg::CFG_MUX_LSB{1'b0}}})) |
								adcs_pkg::CFG_SINGLE_SHOT;
							phase_d     = adcs_pkg::PH_LO_DONE;
							job_valid   = 1'b1;
							job.kind    = adcs_pkg::JOB_SAMPLE;
							job.channel = ch_q;
							job.value   = {event_req.read_data, 1'b0};
						end
						default: begin
							job_valid = 1'b0;
						end
					endcase
				end
			end
			adcs_pkg::CMD_ALERT: begin
				phase_d = adcs_pkg::PH_POLL;
				do_kick = 1'b1;
			end
			adcs_pkg::CMD_KICK: begin
				do_kick = 1'b1;
			end
			default: begin
				do_kick = 1'b0;
			end
		endcase
		if (do_kick) begin
			if (kick_phase == adcs_pkg::PH_POLL) begin
				job_valid = 1'b1;
				job.kind  = adcs_pkg::JOB_CONV_READ;
				job.addr  = dev_q;
			end else if ((kick_phase == adcs_pkg::PH_PROBE) && (&seen_q)) begin
				seen_d    = '0;
				job_valid = 1'b1;
				job.kind  = adcs_pkg::JOB_PROBE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= adcs_pkg::PH_PROBE;
		end else if (accept) begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_q <= '0;
			ch_q   <= '0;
			cw_q   <= adcs_pkg::CONFIG_RESET_DEFAULT;
			dev_q  <= adcs_pkg::ADDR_NONE;
			seen_q <= '1;
		end else if (accept) begin
			fail_q <= fail_d;
			ch_q   <= ch_d;
			cw_q   <= cw_d;
			dev_q  <= dev_d;
			seen_q <= seen_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_limit_q <= adcs_pkg::FAIL_LIMIT_DEFAULT;
			cfg_reset_q  <= adcs_pkg::CONFIG_RESET_DEFAULT;
			hi_thr_q     <= adcs_pkg::HI_THRESHOLD_DEFAULT;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				adcs_pkg::CFG_FAIL_LIMIT:   fail_limit_q <= cfg_wdata[adcs_pkg::FAIL_W-1:0];
				adcs_pkg::CFG_CONFIG_RESET: cfg_reset_q  <= cfg_wdata;
				adcs_pkg::CFG_HI_THRESHOLD: hi_thr_q     <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	`ASSERT_CLK(a_seen_onehot_after_stop, clk, arst_n, (accept && (event_req.command == adcs_pkg::CMD_BUS) && !foreign && !event_req.timed_out && !event_req.aborted && event_req.stop_seen) |=> $onehot0(seen_q))

endmodule

[hw/rtl/adcs_queue.sv]
// ---------------------------------------------------------------------------
// Scan sequencer job queue
// Short first-in first-out buffer of jobs between front end and back end.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module adcs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  adcs_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output adcs_pkg::job_t head_job
);

	adcs_pkg::job_t                     mem_q [adcs_pkg::QUEUE_DEPTH];
	logic [adcs_pkg::QUEUE_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [adcs_pkg::QUEUE_CNT_W-1:0]   count_q;

	assign full       = (count_q == adcs_pkg::QUEUE_CNT_W'(adcs_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_NEVER(a_queue_overflow, clk, arst_n, (push && full && !pop) || (count_q > adcs_pkg::QUEUE_CNT_W'(adcs_pkg::QUEUE_DEPTH)))
	`ASSERT_NEVER(a_queue_underflow, clk, arst_n, pop && !head_valid)

endmodule

[hw/rtl/adcs_back.sv]
// ---------------------------------------------------------------------------
// Scan sequencer back end
// Expands each queued job into its result requests, one per cycle while
// result_ready does not stall the output, through a registered output stage.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module adcs_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  adcs_pkg::job_t        head_job,
	output logic                  pop,
	output logic                  result_valid,
	input  logic                  result_ready,
	output adcs_pkg::result_req_t result_req
);

	logic [adcs_pkg::CH_W-1:0] idx_q;
	logic                      res_valid_q;
	adcs_pkg::result_req_t     res_q, res;
	logic                      load, final_step;

	assign load         = head_valid && (!res_valid_q || result_ready);
	assign pop          = load && final_step;
	assign result_valid = res_valid_q;
	assign result_req   = res_q;

	always_comb begin
		res         = '0;
		final_step  = 1'b1;
		unique case (head_job.kind)
			adcs_pkg::JOB_RETRY: begin
				res.action = adcs_pkg::ACT_RETRY;
			end
			adcs_pkg::JOB_PROBE: begin
				res.action      = adcs_pkg::ACT_PROBE_READ;
				res.target_addr = adcs_pkg::PROBE_ADDR_BASE + adcs_pkg::ADDR_W'(idx_q);
				res.reg_pointer = adcs_pkg::PTR_CONFIG;
				final_step      = (idx_q == adcs_pkg::CH_W'(adcs_pkg::CHANNELS - 1));
			end
			adcs_pkg::JOB_CONV_READ: begin
				res.action      = adcs_pkg::ACT_CONV_READ;
				res.target_addr = head_job.addr;
				res.reg_pointer = adcs_pkg::PTR_CONV;
			end
			adcs_pkg::JOB_WRITE: begin
				res.action      = adcs_pkg::ACT_REG_WRITE;
				res.target_addr = head_job.addr;
				res.reg_pointer = head_job.pointer;
				res.write_word  = head_job.word;
			end
			adcs_pkg::JOB_SAMPLE: begin
				if (idx_q == '0) begin
					res.action         = adcs_pkg::ACT_SAMPLE;
					res.sample_channel = head_job.channel;
					res.sample_value   = head_job.value;
					final_step         = 1'b0;
				end else begin
					res.action      = adcs_pkg::ACT_REG_WRITE;
					res.target_addr = head_job.addr;
					res.reg_pointer = adcs_pkg::PTR_LO_THR;
				end
			end
			default: begin
				res.action = adcs_pkg::ACT_RETRY;
			end
		endcase
		res.last = final_step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
				idx_q       <= final_step ? '0 : idx_q + 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	`ASSERT_CLK(a_idx_only_multi, clk, arst_n, (idx_q != '0) |-> (head_valid && ((head_job.kind == adcs_pkg::JOB_PROBE) || (head_job.kind == adcs_pkg::JOB_SAMPLE))))

endmodule
